[src/odometer_loop_closure_detector_assert.svh]
// Assertion macros for the odometer loop closure detector checkers.
// Depends on nothing; included by the checker file.
`ifndef ODOMETER_LOOP_CLOSURE_DETECTOR_ASSERT_SVH
`define ODOMETER_LOOP_CLOSURE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define OLCD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication
`define OLCD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[src/olcd_pkg.sv]
// Shared types, codes and constants of the odometer loop closure detector.
// No dependencies.
`default_nettype none

package olcd_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int SQ_W   = 49;   // squared step or origin distance
	localparam int RSQ_W  = 46;   // squared close radius

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] REG_CLOSE_RADIUS = 2'd0;
	localparam logic [1:0] REG_MIN_PATH     = 2'd1;
	localparam logic [1:0] REG_MIN_SAMPLES  = 2'd2;

	localparam logic [22:0] CLOSE_RADIUS_RST = 23'd205;
	localparam logic [39:0] MIN_PATH_RST     = 40'd3072;
	localparam logic [15:0] MIN_SAMPLES_RST  = 16'd10;

	localparam logic [2:0] MSTEP_LAST = 3'd5;

	localparam logic [39:0] DIST_MAX  = 40'hFF_FFFF_FFFF;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic               opcode;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [15:0] heading;
	} in_item_t;

	typedef struct packed {
		logic [39:0]        path_length;
		logic signed [31:0] heading_total;
		logic [15:0]        sample_count;
		logic               loop_done;
		logic               is_recording;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQRT,
		ST_FIN
	} olcd_state_t;

endpackage

`default_nettype wire

[src/olcd_channels.sv]
// Valid/ready channel interfaces for the detector's sample and result streams.
// Depends on olcd_pkg.
`default_nettype none

interface olcd_in_if;
	import olcd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface olcd_out_if;
	import olcd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/odometer_loop_closure_detector.sv]
// Odometer loop closure detector: top level with sequencer, shared multiplier and
// bit-serial square root. Depends on olcd_pkg and olcd_channels.
//
// A sample taken while recording runs through a 25x25 multiplier shared by the
// products (step dx^2, dy^2, origin dx^2, dy^2, radius^2) and a 25-iteration
// restoring square root, then an update step. The next transaction is taken
// only after that update, so one sample is processed at a time. Start commands
// and samples while idle go straight to the update. item.ready is high only
// while the sequencer is idle; one result register decouples the result side,
// so a stalled result delays only the update of the next transaction. Registers
// sit at byte addresses 0, 8, 16 on a 64-bit APB port; writes are expected only
// while the block is idle.
`default_nettype none

module odometer_loop_closure_detector (
	input  wire                          clk,
	input  wire                          arst_n,
	olcd_in_if.sink                      item,
	olcd_out_if.source                   result,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [olcd_pkg::ADDR_W-1:0]   paddr,
	input  wire [olcd_pkg::DATA_W-1:0]   pwdata,
	output logic [olcd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import olcd_pkg::*;

	// configuration
	logic [22:0] close_radius_q;
	logic [39:0] min_path_q;
	logic [15:0] min_samples_q;

	// tracking state
	logic               active_q;
	logic [39:0]        dist_q;
	logic signed [31:0] yaw_q;
	logic signed [15:0] prior_h_q;
	logic [15:0]        count_q;
	logic signed [23:0] origin_x_q, origin_y_q, prior_x_q, prior_y_q;

	// transaction capture
	in_item_t item_q;

	// sequencer
	olcd_state_t state_q, state_nxt;
	logic        accept, mul_run, sqrt_run, fin_fire, out_free;
	logic [2:0]  mstep_q;

	// multiplier datapath
	logic signed [23:0] px, py, ox, oy;
	logic signed [24:0] dxp, dyp, dxo, dyo, mul_a;
	logic signed [49:0] mul_full;
	logic [47:0]        prod_q;
	logic [SQ_W-1:0]    step_sq_q, orig_sq_q;
	logic [RSQ_W-1:0]   rad_sq_q;

	// square root datapath
	logic [SQ_W-1:0] rem_q, res_q, bit_q;
	logic [SQ_W:0]   trial;
	logic            ge;

	// update datapath
	logic               first;
	logic [40:0]        dist_sum;
	logic [39:0]        dist_new, dist_after;
	logic signed [17:0] dh, dw;
	logic signed [33:0] yaw_sum;
	logic signed [31:0] yaw_new;
	logic [15:0]        count_new;
	logic               done;
	logic               take_sample;

	// output register
	logic      out_valid_q;
	out_item_t out_q, out_nxt;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_radius_q <= CLOSE_RADIUS_RST;
			min_path_q     <= MIN_PATH_RST;
			min_samples_q  <= MIN_SAMPLES_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				REG_CLOSE_RADIUS: close_radius_q <= pwdata[22:0];
				REG_MIN_PATH:     min_path_q     <= pwdata[39:0];
				REG_MIN_SAMPLES:  min_samples_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_CLOSE_RADIUS: prdata = {41'd0, close_radius_q};
			REG_MIN_PATH:     prdata = {24'd0, min_path_q};
			REG_MIN_SAMPLES:  prdata = {48'd0, min_samples_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					if (item.payload.opcode == OP_SAMPLE && active_q)
						state_nxt = ST_MUL;
					else
						state_nxt = ST_FIN;
				end
			end
			ST_MUL: begin
				if (mstep_q == MSTEP_LAST)
					state_nxt = ST_SQRT;
			end
			ST_SQRT: begin
				if (bit_q[0])
					state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		mul_run    = 1'b0;
		sqrt_run   = 1'b0;
		fin_fire   = 1'b0;
		case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_MUL:  mul_run    = 1'b1;
			ST_SQRT: sqrt_run   = 1'b1;
			ST_FIN:  fin_fire   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstep_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (mul_run)
				mstep_q <= mstep_q + 3'd1;
			else
				mstep_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= item.payload;
	end

	// ---------------- shared multiplier ----------------
	// the first sample after start is its own origin and prior point
	assign first = (count_q == 16'd0);
	assign px = first ? item_q.pos_x : prior_x_q;
	assign py = first ? item_q.pos_y : prior_y_q;
	assign ox = first ? item_q.pos_x : origin_x_q;
	assign oy = first ? item_q.pos_y : origin_y_q;

	assign dxp = {item_q.pos_x[23], item_q.pos_x} - {px[23], px};
	assign dyp = {item_q.pos_y[23], item_q.pos_y} - {py[23], py};
	assign dxo = {item_q.pos_x[23], item_q.pos_x} - {ox[23], ox};
	assign dyo = {item_q.pos_y[23], item_q.pos_y} - {oy[23], oy};

	always_comb begin
		case (mstep_q)
			3'd0:    mul_a = dxp;
			3'd1:    mul_a = dyp;
			3'd2:    mul_a = dxo;
			3'd3:    mul_a = dyo;
			default: mul_a = {2'b00, close_radius_q};
		endcase
	end

	assign mul_full = mul_a * mul_a;

	// product is registered; it is folded into its sum in the next cycle
	always_ff @(posedge clk) begin
		if (mul_run) begin
			prod_q <= mul_full[47:0];
			case (mstep_q)
				3'd1: step_sq_q <= {1'b0, prod_q};
				3'd2: step_sq_q <= step_sq_q + {1'b0, prod_q};
				3'd3: orig_sq_q <= {1'b0, prod_q};
				3'd4: orig_sq_q <= orig_sq_q + {1'b0, prod_q};
				3'd5: rad_sq_q  <= prod_q[RSQ_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- bit-serial square root ----------------
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign ge    = ({1'b0, rem_q} >= trial);

	always_ff @(posedge clk) begin
		if (mul_run && mstep_q == MSTEP_LAST) begin
			rem_q <= step_sq_q;
			res_q <= '0;
			bit_q <= {1'b1, {(SQ_W-1){1'b0}}};
		end else if (sqrt_run) begin
			if (ge) begin
				rem_q <= rem_q - trial[SQ_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// ---------------- update ----------------
	assign take_sample = (item_q.opcode == OP_SAMPLE) && active_q;

	assign dist_sum = {1'b0, dist_q} + {16'd0, res_q[24:0]};
	assign dist_new = dist_sum[40] ? DIST_MAX : dist_sum[39:0];

	// heading difference wraps to [-pi, pi], exactly pi keeps its sign
	assign dh = {{2{item_q.heading[15]}}, item_q.heading} - {{2{prior_h_q[15]}}, prior_h_q};
	always_comb begin
		if (dh > 18'sd32768)
			dw = dh - 18'sd65536;
		else if (dh < -18'sd32768)
			dw = dh + 18'sd65536;
		else
			dw = dh;
	end

	assign yaw_sum = {{2{yaw_q[31]}}, yaw_q} + {{16{dw[17]}}, dw};
	always_comb begin
		if (yaw_sum > 34'sd2147483647)
			yaw_new = 32'sh7FFF_FFFF;
		else if (yaw_sum < -34'sd2147483648)
			yaw_new = 32'sh8000_0000;
		else
			yaw_new = yaw_sum[31:0];
	end

	assign count_new  = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 16'd1;
	assign dist_after = first ? dist_q : dist_new;
	assign done = take_sample && (count_new >= min_samples_q)
		&& (orig_sq_q < {3'd0, rad_sq_q}) && (dist_after > min_path_q);

	always_comb begin
		out_nxt.path_length   = dist_q;
		out_nxt.heading_total = yaw_q;
		out_nxt.sample_count  = count_q;
		out_nxt.loop_done     = 1'b0;
		out_nxt.is_recording  = active_q;
		if (item_q.opcode == OP_START) begin
			out_nxt.path_length  = '0;
			out_nxt.sample_count = '0;
			out_nxt.is_recording = 1'b1;
		end else if (take_sample) begin
			out_nxt.path_length   = dist_after;
			out_nxt.heading_total = first ? yaw_q : yaw_new;
			out_nxt.sample_count  = count_new;
			out_nxt.loop_done     = done;
			out_nxt.is_recording  = !done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			dist_q    <= '0;
			yaw_q     <= '0;
			prior_h_q <= '0;
			count_q   <= '0;
		end else if (fin_fire) begin
			active_q <= out_nxt.is_recording;
			dist_q   <= out_nxt.path_length;
			yaw_q    <= out_nxt.heading_total;
			count_q  <= out_nxt.sample_count;
			if (take_sample)
				prior_h_q <= item_q.heading;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire && take_sample) begin
			prior_x_q <= item_q.pos_x;
			prior_y_q <= item_q.pos_y;
			if (first) begin
				origin_x_q <= item_q.pos_x;
				origin_y_q <= item_q.pos_y;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_fire)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_fire)
			out_q <= out_nxt;
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

endmodule

`default_nettype wire

[src/olcd_checker.sv]
// Port-level checker for the odometer loop closure detector, bound to the top.
// Depends on olcd_pkg and odometer_loop_closure_detector_assert.svh.
`default_nettype none
`include "odometer_loop_closure_detector_assert.svh"

module olcd_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 item_valid,
	input wire                 item_ready,
	input wire                 result_valid,
	input wire                 result_ready,
	input olcd_pkg::out_item_t result_payload
);
	import olcd_pkg::*;

	// one transaction at a time: ready drops right after acceptance
	`OLCD_ASSERT_NXT(a_busy_after_accept, clk, arst_n, item_valid && item_ready, !item_ready)

	// a completed loop always ends recording, with a nonzero sample count
	`OLCD_ASSERT_IMP(a_done_stops, clk, arst_n, result_valid && result_payload.loop_done, !result_payload.is_recording && result_payload.sample_count != 16'd0)

	`OLCD_ASSERT_NXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid)

	`OLCD_ASSERT_NXT(a_payload_holds, clk, arst_n, result_valid && !result_ready, $stable(result_payload))

endmodule

bind odometer_loop_closure_detector olcd_checker u_olcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_payload (result.payload)
);

`default_nettype wire

[tb/odometer_loop_closure_detector_tb.sv]
// Self-checking testbench for odometer_loop_closure_detector: a queue-fed driver, a
// result monitor and a transaction-level path/heading predictor, with APB register phases.
// Depends on olcd_pkg, olcd_channels and the detector top level.
`timescale 1ns / 1ps

module odometer_loop_closure_detector_tb;
	import olcd_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [ADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	olcd_in_if  item_ch ();
	olcd_out_if res_ch ();

	odometer_loop_closure_detector uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	in_item_t  sample_q[$];
	out_item_t status_q[$];
	int unsigned bad_cnt = 0;
	int unsigned cyc = 0;

	// no random idling on either side inside this window
	wire calm = (cyc >= 6000) && (cyc < 12000);

	// predictor copy of the block state and registers
	bit          rec_on     = 1'b0;
	logic [39:0] path_acc   = '0;
	longint      turn_acc   = 0;
	longint      last_hdg   = 0;
	longint      org_x      = 0;
	longint      org_y      = 0;
	longint      last_x     = 0;
	longint      last_y     = 0;
	logic [15:0] n_seen     = '0;
	logic [22:0] cfg_radius   = CLOSE_RADIUS_RST;
	logic [39:0] cfg_min_path = MIN_PATH_RST;
	logic [15:0] cfg_min_n    = MIN_SAMPLES_RST;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned sq_span(longint ax, longint ay, longint bx, longint by);
		longint dx;
		longint dy;
		dx = ax - bx;
		dy = ay - by;
		return dx * dx + dy * dy;
	endfunction

	function automatic out_item_t track_status(in_item_t it);
		out_item_t       r;
		longint          x;
		longint          y;
		longint          h;
		longint          d;
		longint unsigned total;
		longint unsigned r_sq;
		bit              done;
		done = 1'b0;
		if (it.opcode == OP_START) begin
			rec_on = 1'b1;
			path_acc = '0;
			n_seen = '0;
		end else if (rec_on) begin
			x = $signed(it.pos_x);
			y = $signed(it.pos_y);
			h = $signed(it.heading);
			if (n_seen == 0) begin
				org_x = x;
				org_y = y;
			end else begin
				total = path_acc + int_sqrt(sq_span(x, y, last_x, last_y));
				path_acc = (total > DIST_MAX) ? DIST_MAX : total[39:0];
				d = h - last_hdg;
				// exactly +-pi keeps its sign
				if (d > 32768)
					d -= 65536;
				else if (d < -32768)
					d += 65536;
				turn_acc += d;
				if (turn_acc > 64'sd2147483647)
					turn_acc = 64'sd2147483647;
				if (turn_acc < -64'sd2147483648)
					turn_acc = -64'sd2147483648;
			end
			last_x = x;
			last_y = y;
			last_hdg = h;
			if (n_seen < COUNT_MAX)
				n_seen++;
			r_sq = cfg_radius * 64'd1 * cfg_radius;
			if (n_seen >= cfg_min_n && sq_span(x, y, org_x, org_y) < r_sq &&
					path_acc > cfg_min_path) begin
				done = 1'b1;
				rec_on = 1'b0;
			end
		end
		r.path_length   = path_acc;
		r.heading_total = turn_acc[31:0];
		r.sample_count  = n_seen;
		r.loop_done     = done;
		r.is_recording  = rec_on;
		return r;
	endfunction

	// driver: presents queued items, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.payload <= '0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				status_q = {status_q, track_status(item_ch.payload)};
			if (!item_ch.valid || item_ch.ready) begin
				if (sample_q.size() != 0 && !(!calm && $urandom_range(99) < 7)) begin
					item_ch.valid <= 1'b1;
					item_ch.payload <= sample_q.pop_front();
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each result transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (status_q.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("unexpected result: len=%0d turn=%0d n=%0d done=%0b rec=%0b",
							res_ch.payload.path_length, res_ch.payload.heading_total,
							res_ch.payload.sample_count, res_ch.payload.loop_done,
							res_ch.payload.is_recording);
				end else begin
					automatic out_item_t want = status_q.pop_front();
					if (want.path_length !== res_ch.payload.path_length ||
							want.heading_total !== res_ch.payload.heading_total ||
							want.sample_count !== res_ch.payload.sample_count ||
							want.loop_done !== res_ch.payload.loop_done ||
							want.is_recording !== res_ch.payload.is_recording) begin
						bad_cnt++;
						if (bad_cnt <= 10) begin
							$display("mismatch: expected len=%0d turn=%0d n=%0d done=%0b rec=%0b",
								want.path_length, want.heading_total, want.sample_count,
								want.loop_done, want.is_recording);
							$display("          got      len=%0d turn=%0d n=%0d done=%0b rec=%0b",
								res_ch.payload.path_length, res_ch.payload.heading_total,
								res_ch.payload.sample_count, res_ch.payload.loop_done,
								res_ch.payload.is_recording);
						end
					end
				end
			end
			res_ch.ready <= !(!calm && $urandom_range(99) < 7);
		end
	end

	task automatic queue_item(logic op, longint x, longint y, longint h);
		in_item_t it;
		it.opcode = op;
		it.pos_x = x[23:0];
		it.pos_y = y[23:0];
		it.heading = h[15:0];
		sample_q = {sample_q, it};
	endtask

	function automatic longint rnd_span(int s);
		return longint'($urandom_range(0, 2 * s)) - s;
	endfunction

	function automatic longint clamp24(longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return v;
	endfunction

	// start, then a walk that mostly ends back near its first point
	task automatic push_loop(int n, int span);
		longint ox;
		longint oy;
		longint cx;
		longint cy;
		longint hd;
		int     i;
		ox = rnd_span(4194304);
		oy = rnd_span(4194304);
		hd = rnd_span(32768);
		cx = ox;
		cy = oy;
		queue_item(OP_START, longint'($urandom), longint'($urandom), longint'($urandom));
		for (i = 0; i < n; i++) begin
			if (i == n - 1 && $urandom_range(3) != 0) begin
				cx = clamp24(ox + rnd_span(150));
				cy = clamp24(oy + rnd_span(150));
			end else if (i != 0) begin
				cx = clamp24(cx + rnd_span(span));
				cy = clamp24(cy + rnd_span(span));
			end
			if ($urandom_range(9) == 0)
				hd = rnd_span(32768);
			else
				hd += rnd_span(9000);
			queue_item(OP_SAMPLE, cx, cy, hd);
		end
	endtask

	task automatic run_random(int target);
		int made;
		int pick;
		int n;
		int span;
		made = 0;
		while (made < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				n = $urandom_range(2, 16);
				span = ($urandom_range(6) == 0) ? 4194304 : $urandom_range(20, 3000);
				push_loop(n, span);
				made += n + 1;
			end else begin
				if (pick < 88)
					queue_item(1'($urandom_range(1)), longint'($urandom),
						longint'($urandom), longint'($urandom));
				else if (pick < 94)
					queue_item(OP_START, longint'($urandom), longint'($urandom),
						longint'($urandom));
				else
					queue_item(OP_SAMPLE, longint'($urandom), longint'($urandom),
						longint'($urandom));
				made++;
			end
		end
	endtask

	// sender holds off until every predicted result has come back
	task automatic drain();
		while (sample_q.size() != 0 || item_ch.valid || status_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(logic [22:0] rad, logic [39:0] mp, logic [15:0] mn);
		apb_write(REG_CLOSE_RADIUS, {41'd0, rad});
		apb_write(REG_MIN_PATH, {24'd0, mp});
		apb_write(REG_MIN_SAMPLES, {48'd0, mn});
		cfg_radius = rad;
		cfg_min_path = mp;
		cfg_min_n = mn;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sample while idle is ignored
		queue_item(OP_SAMPLE, 8388607, -8388608, 32767);
		queue_item(OP_START, -8388608, 8388607, -32768);
		queue_item(OP_SAMPLE, 8388607, 8388607, -16384);
		// heading step of exactly +pi, then -pi, then both wraps
		queue_item(OP_SAMPLE, -8388608, -8388608, 16384);
		queue_item(OP_SAMPLE, -8388608, -8388608, -16384);
		queue_item(OP_SAMPLE, 8388607, 8388607, 32767);
		queue_item(OP_SAMPLE, 0, 0, -32768);
		// restart while recording keeps the heading total
		queue_item(OP_START, 0, 0, 0);
		queue_item(OP_SAMPLE, 0, 0, 0);
		queue_item(OP_SAMPLE, 1024, 0, 8192);
		queue_item(OP_SAMPLE, 2048, 0, 16384);
		queue_item(OP_SAMPLE, 2048, 1024, 24576);
		queue_item(OP_SAMPLE, 2048, 2048, 32767);
		queue_item(OP_SAMPLE, 1024, 2048, -24576);
		queue_item(OP_SAMPLE, 0, 2048, -16384);
		queue_item(OP_SAMPLE, 0, 1024, -8192);
		queue_item(OP_SAMPLE, 0, 512, -4096);
		queue_item(OP_SAMPLE, 0, 0, 0);
		// loop closed above, recording is off again
		queue_item(OP_SAMPLE, 100, 100, 100);
		queue_item(OP_START, 0, 0, 0);
		queue_item(OP_SAMPLE, 5, 5, 0);
		queue_item(OP_START, 0, 0, 0);
		drain();

		set_regs(23'd205, 40'd3072, 16'd10);
		run_random(100);
		drain();
		set_regs(23'h7F_FFFF, 40'd0, 16'd1);
		run_random(100);
		drain();
		set_regs(23'd0, DIST_MAX, COUNT_MAX);
		run_random(100);
		drain();
		set_regs(23'd500, 40'd2000, 16'd0);
		run_random(100);
		drain();
		repeat (3) begin
			set_regs(23'($urandom_range(50, 8000)), 40'($urandom_range(0, 60000)),
				16'($urandom_range(1, 20)));
			run_random(110);
			drain();
		end

		repeat (60) @(posedge clk);
		if (bad_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/olcd_pkg.sv
src/olcd_channels.sv
src/odometer_loop_closure_detector.sv
src/olcd_checker.sv
tb/odometer_loop_closure_detector_tb.sv
